/* rtl/quadrature_decoder_speed_position_macros.svh */
// Assertion macros for the quadrature decoder.
// Included by the top level; relies on signals named clock and reset in scope.
`ifndef QUADRATURE_DECODER_SPEED_POSITION_MACROS_SVH
`define QUADRATURE_DECODER_SPEED_POSITION_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QDSP_ASSERT_IMPLIES(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("qdsp: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define QDSP_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("qdsp: next-cycle check failed");

`endif

/* rtl/qdsp_pkg.sv */
// Shared constants, types and helper functions of the quadrature decoder.
// No dependencies; every RTL module of the block imports this package.
`default_nettype none

package qdsp_pkg;

   // Field and register widths.
   localparam int COUNT_W         = 32;
   localparam int POS_W           = 32;
   localparam int STEP_W          = 2;
   localparam int RPM_W           = 32;
   localparam int ANGLE_W         = 48;
   localparam int ANGLE_FRAC_BITS = 24;
   localparam int RPM_FRAC_BITS   = 8;
   localparam int TPR_W           = 16;
   localparam int MODE_W          = 3;
   localparam int RATE_W          = 16;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_JOINT_ENABLED   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TICKS_PER_ROUND = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENCODING_MODE   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_RATE_HZ  = 2'd3;

   localparam logic              JOINT_ENABLED_RESET = 1'b1;
   localparam logic [TPR_W-1:0]  TPR_RESET           = 16'd512;
   localparam logic [MODE_W-1:0] MODE_RESET          = 3'd4;
   localparam logic [RATE_W-1:0] RATE_RESET          = 16'd100;

   // Item operation codes.
   localparam logic OP_EDGE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Arithmetic of the sample tick.
   localparam int SECONDS_PER_MINUTE = 60;
   localparam int SCALE_W    = RATE_W + 6 + RPM_FRAC_BITS;
   localparam int MUL_B_W    = 32;
   localparam int PROD_W     = COUNT_W + MUL_B_W;
   localparam int TWO_PI_W   = 35;
   localparam logic [TWO_PI_W-1:0] TWO_PI_Q32 = 35'h6487ED511;
   localparam int TWO_PI_HI_W = TWO_PI_W - MUL_B_W;
   localparam logic [MUL_B_W-1:0]     TWO_PI_LO = TWO_PI_Q32[MUL_B_W-1:0];
   localparam logic [TWO_PI_HI_W-1:0] TWO_PI_HI = TWO_PI_Q32[TWO_PI_W-1:MUL_B_W];
   localparam int ANG_SHIFT  = 32 - ANGLE_FRAC_BITS;
   localparam int DIVISOR_W  = TPR_W + MODE_W;
   localparam int NUM_W      = COUNT_W + TWO_PI_W;
   localparam int DIV_STEPS  = (NUM_W + 1) / 2;
   localparam int DIV_W      = 2 * DIV_STEPS;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   // Queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic                     joint_enabled;
      logic [TPR_W-1:0]         ticks_per_round;
      logic [MODE_W-1:0]        encoding_mode;
      logic [RATE_W-1:0]        sample_rate_hz;
   } qdsp_cfg_type;

   typedef struct packed {
      logic                     is_tick;
      logic signed [STEP_W-1:0] step;
      logic [COUNT_W-1:0]       count;
   } qdsp_entry_type;

   typedef struct packed {
      logic busy;
      logic done;
   } qdsp_div_status_type;

   typedef struct packed {
      logic [DIVISOR_W-1:0] rem;
      logic                 qbit;
   } qdsp_dstep_type;

   // Step of a transition given {previous A, previous B, new A, new B}.
   function automatic logic signed [STEP_W-1:0] step_lookup(input logic [3:0] idx);
      logic signed [STEP_W-1:0] s;
      case (idx) inside
         4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
         4'd1, 4'd7, 4'd8, 4'd14:  s = -2'sd1;
         default:                  s = 2'sd0;
      endcase
      return s;
   endfunction

   // One restoring division step: shift in a dividend bit, subtract if it fits.
   function automatic qdsp_dstep_type div_step(input logic [DIVISOR_W-1:0] rem,
                                               input logic din,
                                               input logic [DIVISOR_W-1:0] d);
      logic [DIVISOR_W:0] trial;
      qdsp_dstep_type     r;
      trial = {rem, din};
      if (trial >= {1'b0, d}) begin
         r.rem  = DIVISOR_W'(trial - {1'b0, d});
         r.qbit = 1'b1;
      end else begin
         r.rem  = trial[DIVISOR_W-1:0];
         r.qbit = 1'b0;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/qdsp_front.sv */
// Front part of the quadrature decoder: takes items, decodes edges, keeps the count.
// Depends on qdsp_pkg; feeds classified items into qdsp_queue.
`default_nettype none

module qdsp_front (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  wire                      req_operation,
   input  wire                      req_phase_a,
   input  wire                      req_phase_b,
   input  wire                      queue_full,
   output logic                     push,
   output qdsp_pkg::qdsp_entry_type push_entry
);
   import qdsp_pkg::*;

   logic [3:0]               history_ff, history_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic [3:0]               idx;
   logic signed [STEP_W-1:0] step;
   logic                     accept;
   logic                     is_tick;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign is_tick   = (req_operation == OP_TICK);
   assign idx       = {history_ff[1:0], req_phase_a, req_phase_b};
   assign step      = step_lookup(idx);

   always_comb begin
      history_in = history_ff;
      count_in   = count_ff;
      if (accept && !is_tick) begin
         history_in = idx;
         count_in   = count_ff + COUNT_W'(step);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         history_ff <= '0;
         count_ff   <= '0;
      end else begin
         history_ff <= history_in;
         count_ff   <= count_in;
      end
   end

   assign push               = accept;
   assign push_entry.is_tick = is_tick;
   assign push_entry.step    = is_tick ? 2'sd0 : step;
   assign push_entry.count   = count_in;

endmodule

`default_nettype wire

/* rtl/qdsp_queue.sv */
// Short item queue that decouples the decoder front from the arithmetic back.
// Depends on qdsp_pkg for the entry type and the depth.
`default_nettype none

module qdsp_queue (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      push,
   input  qdsp_pkg::qdsp_entry_type push_entry,
   output logic                     full,
   input  wire                      pop,
   output logic                     empty,
   output qdsp_pkg::qdsp_entry_type head
);
   import qdsp_pkg::*;

   qdsp_entry_type     entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  fill_ff, fill_in;

   assign full  = (fill_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (fill_ff == '0);
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

/* rtl/qdsp_div.sv */
// Two-lane restoring divider, two quotient bits per lane and cycle, shared divisor.
// Depends on qdsp_pkg; started and read by qdsp_back.
`default_nettype none

module qdsp_div (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   input  wire [qdsp_pkg::DIVISOR_W-1:0]    divisor,
   input  wire [qdsp_pkg::DIV_W-1:0]        num_rpm,
   input  wire [qdsp_pkg::DIV_W-1:0]        num_ang,
   output qdsp_pkg::qdsp_div_status_type    status,
   output logic [qdsp_pkg::DIV_W-1:0]       quo_rpm,
   output logic [qdsp_pkg::DIV_W-1:0]       quo_ang
);
   import qdsp_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [DIVISOR_W-1:0]  rem_rpm_ff, rem_rpm_in, rem_ang_ff, rem_ang_in;
   logic [DIV_W-1:0]      sh_rpm_ff, sh_rpm_in, sh_ang_ff, sh_ang_in;
   qdsp_dstep_type        r1, r2, a1, a2;

   // The dividend shifts out at the top while quotient bits enter at the bottom.
   assign r1 = div_step(rem_rpm_ff, sh_rpm_ff[DIV_W-1], divisor_ff);
   assign r2 = div_step(r1.rem, sh_rpm_ff[DIV_W-2], divisor_ff);
   assign a1 = div_step(rem_ang_ff, sh_ang_ff[DIV_W-1], divisor_ff);
   assign a2 = div_step(a1.rem, sh_ang_ff[DIV_W-2], divisor_ff);

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      divisor_in = divisor_ff;
      rem_rpm_in = rem_rpm_ff;
      rem_ang_in = rem_ang_ff;
      sh_rpm_in  = sh_rpm_ff;
      sh_ang_in  = sh_ang_ff;
      if (start) begin
         busy_in    = 1'b1;
         cnt_in     = DIV_CNT_W'(DIV_STEPS - 1);
         divisor_in = divisor;
         rem_rpm_in = '0;
         rem_ang_in = '0;
         sh_rpm_in  = num_rpm;
         sh_ang_in  = num_ang;
      end else if (busy_ff) begin
         rem_rpm_in = r2.rem;
         rem_ang_in = a2.rem;
         sh_rpm_in  = {sh_rpm_ff[DIV_W-3:0], r1.qbit, r2.qbit};
         sh_ang_in  = {sh_ang_ff[DIV_W-3:0], a1.qbit, a2.qbit};
         cnt_in     = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      divisor_ff <= divisor_in;
      rem_rpm_ff <= rem_rpm_in;
      rem_ang_ff <= rem_ang_in;
      sh_rpm_ff  <= sh_rpm_in;
      sh_ang_ff  <= sh_ang_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quo_rpm     = sh_rpm_ff;
   assign quo_ang     = sh_ang_ff;

endmodule

`default_nettype wire

/* rtl/qdsp_back.sv */
// Back part of the quadrature decoder: speed and angle update, result register.
// Depends on qdsp_pkg; drains qdsp_queue and drives qdsp_div.
`default_nettype none

module qdsp_back (
   input  wire                                 clock,
   input  wire                                 reset,
   input  qdsp_pkg::qdsp_cfg_type              cfg,
   input  wire                                 queue_empty,
   input  qdsp_pkg::qdsp_entry_type            head,
   output logic                                pop,
   output logic                                div_start,
   output logic [qdsp_pkg::DIVISOR_W-1:0]      div_divisor,
   output logic [qdsp_pkg::DIV_W-1:0]          div_num_rpm,
   output logic [qdsp_pkg::DIV_W-1:0]          div_num_ang,
   input  qdsp_pkg::qdsp_div_status_type       div_status,
   input  wire [qdsp_pkg::DIV_W-1:0]           div_quo_rpm,
   input  wire [qdsp_pkg::DIV_W-1:0]           div_quo_ang,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic signed [qdsp_pkg::POS_W-1:0]   rsp_position_count,
   output logic signed [qdsp_pkg::STEP_W-1:0]  rsp_step_taken,
   output logic signed [qdsp_pkg::RPM_W-1:0]   rsp_motor_rpm,
   output logic signed [qdsp_pkg::ANGLE_W-1:0] rsp_motor_angle
);
   import qdsp_pkg::*;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_MUL_RPM = 3'd1;
   localparam logic [2:0] S_MUL_ANG = 3'd2;
   localparam logic [2:0] S_START   = 3'd3;
   localparam logic [2:0] S_WAIT    = 3'd4;
   localparam logic [2:0] S_DONE    = 3'd5;

   localparam logic [RPM_W-1:0] RPM_MIN = {1'b1, {(RPM_W-1){1'b0}}};
   localparam logic [RPM_W-1:0] RPM_MAX = {1'b0, {(RPM_W-1){1'b1}}};

   logic [2:0]                 state_ff, state_in;
   logic [COUNT_W-1:0]         last_ff, last_in;
   logic [RPM_W-1:0]           speed_ff, speed_in;
   logic [ANGLE_W-1:0]         angle_ff, angle_in;
   logic [COUNT_W-1:0]         mag_ff, mag_in;
   logic                       neg_ff, neg_in;
   logic [COUNT_W-1:0]         hold_ff, hold_in;
   logic [DIV_W-1:0]           num_rpm_ff, num_rpm_in, num_ang_ff, num_ang_in;
   logic                       out_valid_ff, out_valid_in;
   logic [COUNT_W-1:0]         out_count_ff, out_count_in;
   logic signed [STEP_W-1:0]   out_step_ff, out_step_in;
   logic [RPM_W-1:0]           out_rpm_ff, out_rpm_in;
   logic [ANGLE_W-1:0]         out_angle_ff, out_angle_in;

   logic                       out_free;
   logic                       divisor_zero;
   logic [COUNT_W-1:0]         delta;
   logic [SCALE_W-1:0]         rpm_scale;
   logic [MUL_B_W-1:0]         mul_b;
   logic [PROD_W-1:0]          product;
   logic [COUNT_W+TWO_PI_HI_W-1:0] ang_hi_prod;
   logic [RPM_W-1:0]           speed_sat;
   logic [ANGLE_W-1:0]         angle_step;

   assign out_free     = !out_valid_ff || !rsp_stall;
   assign divisor_zero = (cfg.ticks_per_round == '0) || (cfg.encoding_mode == '0);
   assign div_divisor  = DIVISOR_W'(cfg.ticks_per_round * cfg.encoding_mode);
   assign delta        = head.count - last_ff;
   assign rpm_scale    = (SCALE_W'(cfg.sample_rate_hz) * SCALE_W'(SECONDS_PER_MINUTE))
                         << RPM_FRAC_BITS;

   // One shared multiplier: speed scale first, then the low word of two pi.
   assign mul_b       = (state_ff == S_MUL_RPM) ? MUL_B_W'(rpm_scale) : TWO_PI_LO;
   assign product     = PROD_W'(mag_ff) * PROD_W'(mul_b);
   assign ang_hi_prod = mag_ff * TWO_PI_HI;

   assign div_num_rpm = num_rpm_ff;
   assign div_num_ang = num_ang_ff;
   assign angle_step  = div_quo_ang[ANG_SHIFT +: ANGLE_W];

   always_comb begin
      if (neg_ff) begin
         if ((|div_quo_rpm[DIV_W-1:RPM_W]) || (div_quo_rpm[RPM_W-1:0] > RPM_MIN)) begin
            speed_sat = RPM_MIN;
         end else begin
            speed_sat = -div_quo_rpm[RPM_W-1:0];
         end
      end else begin
         if (|div_quo_rpm[DIV_W-1:RPM_W-1]) begin
            speed_sat = RPM_MAX;
         end else begin
            speed_sat = div_quo_rpm[RPM_W-1:0];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      last_in      = last_ff;
      speed_in     = speed_ff;
      angle_in     = angle_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      hold_in      = hold_ff;
      num_rpm_in   = num_rpm_ff;
      num_ang_in   = num_ang_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_count_in = out_count_ff;
      out_step_in  = out_step_ff;
      out_rpm_in   = out_rpm_ff;
      out_angle_in = out_angle_ff;
      pop          = 1'b0;
      div_start    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (!queue_empty && out_free) begin
               pop = 1'b1;
               if (!head.is_tick || !cfg.joint_enabled) begin
                  out_valid_in = 1'b1;
                  out_count_in = head.count;
                  out_step_in  = head.step;
                  out_rpm_in   = speed_ff;
                  out_angle_in = angle_ff;
               end else begin
                  last_in = head.count;
                  if (divisor_zero) begin
                     speed_in     = '0;
                     out_valid_in = 1'b1;
                     out_count_in = head.count;
                     out_step_in  = 2'sd0;
                     out_rpm_in   = '0;
                     out_angle_in = angle_ff;
                  end else begin
                     neg_in   = delta[COUNT_W-1];
                     mag_in   = delta[COUNT_W-1] ? -delta : delta;
                     hold_in  = head.count;
                     state_in = S_MUL_RPM;
                  end
               end
            end
         end
         S_MUL_RPM: begin
            num_rpm_in = DIV_W'(product);
            state_in   = S_MUL_ANG;
         end
         S_MUL_ANG: begin
            num_ang_in = DIV_W'(product) + (DIV_W'(ang_hi_prod) << MUL_B_W);
            state_in   = S_START;
         end
         S_START: begin
            div_start = 1'b1;
            state_in  = S_WAIT;
         end
         S_WAIT: begin
            if (div_status.done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               speed_in     = speed_sat;
               angle_in     = neg_ff ? angle_ff - angle_step : angle_ff + angle_step;
               out_valid_in = 1'b1;
               out_count_in = hold_ff;
               out_step_in  = 2'sd0;
               out_rpm_in   = speed_sat;
               out_angle_in = neg_ff ? angle_ff - angle_step : angle_ff + angle_step;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         last_ff      <= '0;
         speed_ff     <= '0;
         angle_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         speed_ff     <= speed_in;
         angle_ff     <= angle_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      hold_ff      <= hold_in;
      num_rpm_ff   <= num_rpm_in;
      num_ang_ff   <= num_ang_in;
      out_count_ff <= out_count_in;
      out_step_ff  <= out_step_in;
      out_rpm_ff   <= out_rpm_in;
      out_angle_ff <= out_angle_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_position_count = POS_W'(signed'(out_count_ff));
   assign rsp_step_taken     = out_step_ff;
   assign rsp_motor_rpm      = out_rpm_ff;
   assign rsp_motor_angle    = out_angle_ff;

endmodule

`default_nettype wire

/* rtl/quadrature_decoder_speed_position.sv */
// Top level of the quadrature decoder with speed and position estimate.
// Depends on qdsp_pkg, qdsp_front, qdsp_queue, qdsp_div, qdsp_back and the macro header.
`default_nettype none
`include "quadrature_decoder_speed_position_macros.svh"

// Each item is either an encoder edge carrying the A/B pin levels or a sample tick, and
// each item produces exactly one result item with the count, the step of that edge, the
// last speed in rpm (8 fraction bits, saturated) and the wrapping angle in radians (24
// fraction bits). The front takes an item in the cycle it arrives, decodes the edge and
// updates the count straight away, then places the item in a four-entry queue, so input
// is held off only once that queue is full. The back drains the queue one item at a
// time: an edge, or a tick on a disabled joint or with a zero divisor, goes straight into
// the result register once it is free. An enabled tick passes S_MUL_RPM and S_MUL_ANG on
// the shared 32 by 32 multiplier, then S_START and S_WAIT on the two-lane divider, which
// retires two quotient bits per cycle over a 68-bit dividend, and S_DONE to saturate.
// Configuration registers are always ready and should only be written while no item is
// outstanding. Reset is synchronous and active high; there is no clearing pass.
module quadrature_decoder_speed_position (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire                                 req_operation,
   input  wire                                 req_phase_a,
   input  wire                                 req_phase_b,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic signed [qdsp_pkg::POS_W-1:0]   rsp_position_count,
   output logic signed [qdsp_pkg::STEP_W-1:0]  rsp_step_taken,
   output logic signed [qdsp_pkg::RPM_W-1:0]   rsp_motor_rpm,
   output logic signed [qdsp_pkg::ANGLE_W-1:0] rsp_motor_angle,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire [qdsp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire [qdsp_pkg::CSR_DATA_W-1:0]      csr_data
);
   import qdsp_pkg::*;

   qdsp_cfg_type        cfg_ff, cfg_in;
   logic                push;
   qdsp_entry_type      push_entry;
   logic                queue_full;
   logic                queue_empty;
   logic                pop;
   qdsp_entry_type      head;
   logic                div_start;
   logic [DIVISOR_W-1:0] div_divisor;
   logic [DIV_W-1:0]    div_num_rpm, div_num_ang;
   qdsp_div_status_type div_status;
   logic [DIV_W-1:0]    div_quo_rpm, div_quo_ang;

   // The register file is a plain write port; it never pushes back.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_JOINT_ENABLED:   cfg_in.joint_enabled   = csr_data[0];
            CSR_TICKS_PER_ROUND: cfg_in.ticks_per_round = csr_data[TPR_W-1:0];
            CSR_ENCODING_MODE:   cfg_in.encoding_mode   = csr_data[MODE_W-1:0];
            CSR_SAMPLE_RATE_HZ:  cfg_in.sample_rate_hz  = csr_data[RATE_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.joint_enabled   <= JOINT_ENABLED_RESET;
         cfg_ff.ticks_per_round <= TPR_RESET;
         cfg_ff.encoding_mode   <= MODE_RESET;
         cfg_ff.sample_rate_hz  <= RATE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Edge decoding and the running count live in the front.
   qdsp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_phase_a   (req_phase_a),
      .req_phase_b   (req_phase_b),
      .queue_full    (queue_full),
      .push          (push),
      .push_entry    (push_entry)
   );

   qdsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .empty      (queue_empty),
      .head       (head)
   );

   // Speed and angle share one divisor, so both quotients come out together.
   qdsp_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .divisor (div_divisor),
      .num_rpm (div_num_rpm),
      .num_ang (div_num_ang),
      .status  (div_status),
      .quo_rpm (div_quo_rpm),
      .quo_ang (div_quo_ang)
   );

   qdsp_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .queue_empty        (queue_empty),
      .head               (head),
      .pop                (pop),
      .div_start          (div_start),
      .div_divisor        (div_divisor),
      .div_num_rpm        (div_num_rpm),
      .div_num_ang        (div_num_ang),
      .div_status         (div_status),
      .div_quo_rpm        (div_quo_rpm),
      .div_quo_ang        (div_quo_ang),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_position_count (rsp_position_count),
      .rsp_step_taken     (rsp_step_taken),
      .rsp_motor_rpm      (rsp_motor_rpm),
      .rsp_motor_angle    (rsp_motor_angle)
   );

   // The front must never write into a full queue, nor the back read an empty one.
   `QDSP_ASSERT_IMPLIES(a_push_not_full, push, !queue_full)
   `QDSP_ASSERT_IMPLIES(a_pop_not_empty, pop, !queue_empty)
   // The divider is started only when idle, and runs once started.
   `QDSP_ASSERT_IMPLIES(a_start_when_idle, div_start, !div_status.busy)
   `QDSP_ASSERT_NEXT(a_start_then_busy, div_start, div_status.busy)

endmodule

`default_nettype wire
